### src/oahs_pkg.sv
package oahs_pkg;

    localparam int KEY_W      = 64;
    localparam int HASH_W     = 32;
    localparam int CMD_W      = 2;
    localparam int MOD_W      = 11;
    localparam int SLOT_OUT_W = 10;
    localparam int LIVE_OUT_W = 11;
    localparam int S_DATA_W   = 96;
    localparam int M_DATA_W   = 24;
    localparam int DIV_CNT_W  = $clog2(HASH_W + 1);

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [HASH_W-1:0] HASH_FREE = 32'd0;
    localparam logic [HASH_W-1:0] HASH_TOMB = 32'd1;
    localparam logic [HASH_W-1:0] HASH_MIN  = 32'd2;
    localparam logic [HASH_W-1:0] HOME_MULT = 32'd11;

    localparam logic [MOD_W-1:0] MOD_RESET = 11'd1021;
    localparam logic [MOD_W-1:0] MOD_MIN   = 11'd2;

    typedef struct packed {
        logic rd_en;
        logic hash_we;
        logic key_we;
    } store_ctl_t;

endpackage

### src/open_address_hash_set_core.sv
// Channel   Dir  tdata                             tuser
// s_*       in   key[63:0], hval[95:64]            cmd[1:0]
// m_*       out  hit, slot_index, table_full,      -
//                live_entries (see port)
// cfg_*     in   table_modulus[10:0]               -
// One command at a time. Lookup/insert/remove: accept, start the modulo, the
// bit-serial remainder unit (32 steps, then the done cycle), memory read and
// compare per probe, update, then hand the word to the output register.
// Clear sweeps the hash memory one slot a cycle.
// After reset the same sweep runs with s_tready low.
// A new command is taken while the previous result waits in the output register.
module open_address_hash_set_core
    import oahs_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [MOD_W-1:0]      cfg_wr_data,   // table_modulus
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,       // key[63:0], hval[95:64]
    input  logic [CMD_W-1:0]      s_tuser,       // cmd[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata        // hit[0], slot_index[10:1],
                                                 // table_full[11], live_entries[22:12]
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = SW + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_DIV  = 8'b00000100,
        S_RD   = 8'b00001000,
        S_CHK  = 8'b00010000,
        S_ACT  = 8'b00100000,
        S_DONE = 8'b01000000,
        S_CLR  = 8'b10000000
    } state_t;

    state_t              state_reg, state_next;
    logic [MOD_W-1:0]    mod_reg, mod_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [SW-1:0]       idx_reg, idx_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [SW-1:0]       tomb_reg, tomb_next;
    logic                tomb_ok_reg, tomb_ok_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic                found_reg, found_next;
    logic                full_reg, full_next;
    logic                unused_end_reg, unused_end_next;
    logic [SW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                clr_cmd_reg, clr_cmd_next;
    logic [CW-1:0]       live_reg, live_next;
    logic [CW-1:0]       used_reg, used_next;
    logic                res_hit_reg, res_hit_next;
    logic [SW-1:0]       res_slot_reg, res_slot_next;
    logic                res_full_reg, res_full_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                div_start, div_done;
    logic [MOD_W-1:0]    div_rem, mod_eff;
    logic [HASH_W-1:0]   home_prod, in_hash, rd_hash, wr_hash;
    logic [KEY_W-1:0]    rd_key;
    logic [SW-1:0]       st_addr;
    store_ctl_t          st_ctl;
    logic                key_match, tomb_upd;
    logic [SW-1:0]       step_inc;
    logic [31:0]         slot_wide, live_wide, rem_wide;

    assign mod_eff   = (mod_reg < MOD_MIN) ? MOD_MIN : mod_reg;
    assign home_prod = HASH_W'(hash_reg * HOME_MULT);
    assign div_start = (state_reg == S_MUL);
    assign in_hash   = (s_tdata[S_DATA_W-1:KEY_W] < HASH_MIN) ? HASH_MIN
                                                               : s_tdata[S_DATA_W-1:KEY_W];
    assign key_match = (rd_hash == hash_reg) && (rd_key == key_reg);
    assign tomb_upd  = (rd_hash == HASH_TOMB) && !tomb_ok_reg;
    assign step_inc  = step_reg + 1'b1;
    assign slot_wide = 32'(res_slot_reg);
    assign live_wide = 32'(live_reg);
    assign rem_wide  = 32'(div_rem);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    oahs_moddiv u_moddiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (home_prod),
        .divisor  (mod_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    oahs_store #(.SLOT_W(SW)) u_store (
        .aclk    (aclk),
        .ctl     (st_ctl),
        .addr    (st_addr),
        .wr_hash (wr_hash),
        .wr_key  (key_reg),
        .rd_hash (rd_hash),
        .rd_key  (rd_key)
    );

    // memory port control
    always_comb begin
        st_ctl  = '0;
        st_addr = idx_reg;
        wr_hash = HASH_FREE;
        if (state_reg == S_CLR) begin
            st_ctl.hash_we = 1'b1;
            st_addr        = clr_cnt_reg;
        end else if (state_reg == S_RD) begin
            st_ctl.rd_en = 1'b1;
        end else if (state_reg == S_ACT) begin
            st_addr = slot_reg;
            if (!full_reg && cmd_reg == CMD_INSERT && !found_reg) begin
                st_ctl.hash_we = 1'b1;
                st_ctl.key_we  = 1'b1;
                wr_hash        = hash_reg;
            end else if (!full_reg && cmd_reg == CMD_REMOVE && found_reg) begin
                st_ctl.hash_we = 1'b1;
                wr_hash        = HASH_TOMB;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        mod_next        = cfg_wr_en ? cfg_wr_data : mod_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        hash_next       = hash_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        n_next          = n_reg;
        tomb_next       = tomb_reg;
        tomb_ok_next    = tomb_ok_reg;
        slot_next       = slot_reg;
        found_next      = found_reg;
        full_next       = full_reg;
        unused_end_next = unused_end_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_cmd_next    = clr_cmd_reg;
        live_next       = live_reg;
        used_next       = used_reg;
        res_hit_next    = res_hit_reg;
        res_slot_next   = res_slot_reg;
        res_full_next   = res_full_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tuser;
                    key_next  = s_tdata[KEY_W-1:0];
                    hash_next = in_hash;
                    if (s_tuser == CMD_CLEAR) begin
                        clr_cnt_next = '0;
                        clr_cmd_next = 1'b1;
                        live_next    = '0;
                        used_next    = '0;
                        state_next   = S_CLR;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    idx_next     = rem_wide[SW-1:0];
                    step_next    = '0;
                    n_next       = '0;
                    tomb_ok_next = 1'b0;
                    state_next   = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                full_next       = 1'b0;
                found_next      = 1'b0;
                unused_end_next = 1'b0;
                if (rd_hash == HASH_FREE) begin
                    slot_next       = tomb_ok_reg ? tomb_reg : idx_reg;
                    unused_end_next = !tomb_ok_reg;
                    state_next      = S_ACT;
                end else if (key_match) begin
                    slot_next  = idx_reg;
                    found_next = 1'b1;
                    state_next = S_ACT;
                end else begin
                    tomb_ok_next = tomb_ok_reg || tomb_upd;
                    tomb_next    = tomb_upd ? idx_reg : tomb_reg;
                    if (n_reg == CW'(CAPACITY - 1)) begin
                        // every slot visited
                        if (tomb_ok_reg || tomb_upd) begin
                            slot_next = tomb_upd ? idx_reg : tomb_reg;
                        end else begin
                            slot_next = '0;
                            full_next = 1'b1;
                        end
                        state_next = S_ACT;
                    end else begin
                        step_next  = step_inc;
                        idx_next   = idx_reg + step_inc;
                        n_next     = n_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_ACT: begin
                res_full_next = full_reg;
                res_slot_next = slot_reg;
                res_hit_next  = 1'b0;
                if (!full_reg) begin
                    if (cmd_reg == CMD_LOOKUP) begin
                        res_hit_next = found_reg;
                    end else if (cmd_reg == CMD_INSERT && !found_reg) begin
                        res_hit_next = 1'b1;
                        live_next    = live_reg + 1'b1;
                        used_next    = used_reg + CW'(unused_end_reg);
                    end else if (cmd_reg == CMD_REMOVE && found_reg) begin
                        res_hit_next = 1'b1;
                        live_next    = live_reg - 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, live_wide[LIVE_OUT_W-1:0], res_full_reg,
                                    slot_wide[SLOT_OUT_W-1:0], res_hit_reg};
                    state_next   = S_IDLE;
                end
            end
            S_CLR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SW'(CAPACITY - 1)) begin
                    if (clr_cmd_reg) begin
                        res_hit_next  = 1'b0;
                        res_slot_next = '0;
                        res_full_next = 1'b0;
                        state_next    = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            mod_reg      <= MOD_RESET;
            clr_cnt_reg  <= '0;
            clr_cmd_reg  <= 1'b0;
            live_reg     <= '0;
            used_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mod_reg      <= mod_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_cmd_reg  <= clr_cmd_next;
            live_reg     <= live_next;
            used_reg     <= used_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        hash_reg       <= hash_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        n_reg          <= n_next;
        tomb_reg       <= tomb_next;
        tomb_ok_reg    <= tomb_ok_next;
        slot_reg       <= slot_next;
        found_reg      <= found_next;
        full_reg       <= full_next;
        unused_end_reg <= unused_end_next;
        res_hit_reg    <= res_hit_next;
        res_slot_reg   <= res_slot_next;
        res_full_reg   <= res_full_next;
        m_data_reg     <= m_data_next;
    end

`ifndef SYNTHESIS
    // a tombstone is a slot once used, so live keys never outnumber used slots
    a_live_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= used_reg)
        else $error("live count exceeds used count");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("remainder finished outside modulo wait");

    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACT && full_reg) |-> !st_ctl.hash_we && !st_ctl.key_we)
        else $error("store written on full table");
`endif

endmodule

### src/oahs_moddiv.sv
module oahs_moddiv
    import oahs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [MOD_W-1:0]  divisor,
    output logic              done,
    output logic [MOD_W-1:0]  rem
);

    logic [HASH_W-1:0]    shift_reg, shift_next;
    logic [MOD_W-1:0]     rem_reg, rem_next;
    logic [MOD_W-1:0]     div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_W:0]       trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg, shift_reg[HASH_W-1]};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = MOD_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[MOD_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(HASH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### src/oahs_store.sv
module oahs_store
    import oahs_pkg::*;
#(
    parameter int SLOT_W = 10
) (
    input  logic              aclk,
    input  store_ctl_t        ctl,
    input  logic [SLOT_W-1:0] addr,
    input  logic [HASH_W-1:0] wr_hash,
    input  logic [KEY_W-1:0]  wr_key,
    output logic [HASH_W-1:0] rd_hash,
    output logic [KEY_W-1:0]  rd_key
);

    localparam int DEPTH = 1 << SLOT_W;

    logic [HASH_W-1:0] hash_mem [DEPTH];
    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [HASH_W-1:0] rd_hash_reg;
    logic [KEY_W-1:0]  rd_key_reg;

    always_ff @(posedge aclk) begin
        if (ctl.hash_we) begin
            hash_mem[addr] <= wr_hash;
        end
        if (ctl.rd_en) begin
            rd_hash_reg <= hash_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.key_we) begin
            key_mem[addr] <= wr_key;
        end
        if (ctl.rd_en) begin
            rd_key_reg <= key_mem[addr];
        end
    end

    assign rd_hash = rd_hash_reg;
    assign rd_key  = rd_key_reg;

endmodule
